// ===== rtl/pnpf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the polyline nearest point follower.
package pnpf_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam logic [15:0] LINE_RANGE_RST = 16'd480;
	localparam logic [6:0] POINT_COUNT_RST = 7'd0;

	// configuration register indexes
	localparam logic CFG_LINE_RANGE  = 1'b0;
	localparam logic CFG_POINT_COUNT = 1'b1;

	// item kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// quotient bits of the shared divider
	localparam int DIV_QB = 18;
	// result bits of the square root
	localparam int SQRT_STEPS = 17;

endpackage

// ===== rtl/polyline_nearest_point_follow.sv =====
`timescale 1ns / 1ps
// Path follower: stores up to MAX_POINTS waypoints and, for each query, finds the
// nearest clamped point on the polyline and blends a motion target from it. A write item
// is stored without stalling the input. A query is worked through by one shared 18x18
// multiplier and one shared restoring divider that produces a quotient one bit per cycle,
// rounded for the up to two projection divisions per segment; the waypoint memory is read
// one point per segment. The input is stalled while a query runs; a finished result waits
// in the output register.
module polyline_nearest_point_follow
	import pnpf_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [5:0]         point_index,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic signed [15:0] robot_x,
	input  logic signed [15:0] robot_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] motion_x,
	output logic signed [15:0] motion_y,
	output logic [16:0]        nearest_distance,
	output logic               in_range,
	output logic               path_valid,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int NW = (CW > 7) ? CW : 7;
	localparam int PW = (CW > 6) ? CW : 6;

	typedef enum logic [4:0] {
		ST_IDLE, ST_WA, ST_GA, ST_WB, ST_GB,
		ST_DEN0, ST_DEN1, ST_NUM0, ST_NUM1,
		ST_PX0, ST_PX1, ST_PY0, ST_PY1,
		ST_DSET, ST_DSTEP, ST_DFIN,
		ST_SQ0, ST_SQ1, ST_SQI, ST_SQRT, ST_RNG,
		ST_BLX0, ST_BLX1, ST_BLY0, ST_BLY1, ST_DONE
	} state_t;

	typedef enum logic [1:0] {DM_X, DM_Y, DM_W} div_mode_t;

	state_t state_q;
	div_mode_t dmode_q;

	logic [15:0] line_range_q;
	logic [6:0]  point_count_q;

	logic signed [15:0] mem_x [MAX_POINTS];
	logic signed [15:0] mem_y [MAX_POINTS];
	logic signed [15:0] rdx_q, rdy_q;
	logic [AW-1:0] addr_q;

	logic signed [15:0] rx_q, ry_q, ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [CW-1:0] n_q, nxt_q;
	logic signed [53:0] acc_q;
	logic [33:0] den_q;
	logic signed [34:0] num_q;
	logic neg_q;
	logic [53:0] dwork_q, dsh_q;
	logic [DIV_QB-1:0] dq_q;
	logic [4:0] dcnt_q, scnt_q;
	logic have_q;
	logic [33:0] best_q;
	logic signed [15:0] bestx_q, besty_q, endx_q, endy_q;
	logic [33:0] sv_q, sb_q;
	logic [34:0] sr_q;
	logic [16:0] dist_q, wn_q;
	logic hit_q, pv_q;
	logic signed [15:0] held_x_q, held_y_q;

	// shared multiplier
	logic signed [17:0] ma, mb;
	logic signed [35:0] prod;
	logic signed [53:0] prod_ext, acc_sum;

	logic signed [16:0] dx, dy, rax, ray, ex, ey;
	logic [16:0] we;

	always_comb begin
		dx  = {bx_q[15], bx_q} - {ax_q[15], ax_q};
		dy  = {by_q[15], by_q} - {ay_q[15], ay_q};
		rax = {rx_q[15], rx_q} - {ax_q[15], ax_q};
		ray = {ry_q[15], ry_q} - {ay_q[15], ay_q};
		ex  = {cx_q[15], cx_q} - {rx_q[15], rx_q};
		ey  = {cy_q[15], cy_q} - {ry_q[15], ry_q};
		we  = 17'h10000 - wn_q;
		ma = '0;
		mb = '0;
		case (state_q)
			ST_DEN0: begin ma = {dx[16], dx}; mb = {dx[16], dx}; end
			ST_DEN1: begin ma = {dy[16], dy}; mb = {dy[16], dy}; end
			ST_NUM0: begin ma = {rax[16], rax}; mb = {dx[16], dx}; end
			ST_NUM1: begin ma = {ray[16], ray}; mb = {dy[16], dy}; end
			ST_PX0:  begin ma = {dx[16], dx}; mb = num_q[34:17]; end
			ST_PX1:  begin ma = {dx[16], dx}; mb = {1'b0, num_q[16:0]}; end
			ST_PY0:  begin ma = {dy[16], dy}; mb = num_q[34:17]; end
			ST_PY1:  begin ma = {dy[16], dy}; mb = {1'b0, num_q[16:0]}; end
			ST_SQ0:  begin ma = {ex[16], ex}; mb = {ex[16], ex}; end
			ST_SQ1:  begin ma = {ey[16], ey}; mb = {ey[16], ey}; end
			ST_RNG:  begin ma = {2'b0, line_range_q}; mb = {2'b0, line_range_q}; end
			ST_BLX0: begin ma = {{2{endx_q[15]}}, endx_q}; mb = {1'b0, we}; end
			ST_BLX1: begin ma = {{2{bestx_q[15]}}, bestx_q}; mb = {1'b0, wn_q}; end
			ST_BLY0: begin ma = {{2{endy_q[15]}}, endy_q}; mb = {1'b0, we}; end
			ST_BLY1: begin ma = {{2{besty_q[15]}}, besty_q}; mb = {1'b0, wn_q}; end
			default: begin ma = '0; mb = '0; end
		endcase
		prod = ma * mb;
		prod_ext = {{18{prod[35]}}, prod};
		acc_sum = acc_q + prod_ext;
	end

	// divider setup and step
	logic [53:0] mag, dv_work, dv_lim, dv_sh0, dv_diff;
	logic [34:0] dv_dd;
	logic dv_sat, dv_ge;
	always_comb begin
		mag = acc_q[53] ? 54'(-acc_q) : 54'(acc_q);
		if (dmode_q == DM_W) begin
			dv_work = {21'd0, dist_q, 16'd0};
			dv_dd   = {19'd0, line_range_q};
		end else begin
			dv_work = {mag[52:0], 1'b0} + {20'd0, den_q};
			dv_dd   = {den_q, 1'b0};
		end
		dv_lim  = {1'b0, dv_dd, 18'd0};
		dv_sat  = dv_work >= dv_lim;
		dv_sh0  = {2'b0, dv_dd, 17'd0};
		dv_ge   = dwork_q >= dsh_q;
		dv_diff = dwork_q - dsh_q;
	end

	// offset add and bounding box clamp
	logic signed [18:0] off;
	logic signed [19:0] cval, lo20, hi20;
	logic signed [15:0] ca, cb, cres;
	always_comb begin
		ca = (dmode_q == DM_X) ? ax_q : ay_q;
		cb = (dmode_q == DM_X) ? bx_q : by_q;
		off = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
		cval = {{4{ca[15]}}, ca} + {off[18], off};
		lo20 = (ca < cb) ? {{4{ca[15]}}, ca} : {{4{cb[15]}}, cb};
		hi20 = (ca < cb) ? {{4{cb[15]}}, cb} : {{4{ca[15]}}, ca};
		if (cval < lo20)      cres = lo20[15:0];
		else if (cval > hi20) cres = hi20[15:0];
		else                  cres = cval[15:0];
	end

	// square root step
	logic [34:0] sq_t;
	logic sq_ge;
	always_comb begin
		sq_t  = sr_q + {1'b0, sb_q};
		sq_ge = {1'b0, sv_q} >= sq_t;
	end

	logic [33:0] sq_new;
	logic        take_best;
	logic [CW:0] nxt_inc;
	logic [NW-1:0] pc_ext;
	logic [CW-1:0] n_new;
	logic [PW-1:0] idx_ext;
	logic wr_en;
	logic signed [53:0] blend_s;

	always_comb begin
		sq_new    = acc_sum[33:0];
		take_best = !have_q || (sq_new <= best_q);
		nxt_inc   = {1'b0, nxt_q} + 1'b1;
		pc_ext    = NW'(point_count_q);
		n_new     = (pc_ext > NW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pc_ext[CW-1:0];
		idx_ext   = PW'(point_index);
		wr_en     = (state_q == ST_IDLE) && in_valid && (req_type == REQ_WRITE) &&
			(idx_ext < PW'(MAX_POINTS));
		blend_s   = acc_sum + 54'sd32768;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// waypoint memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[idx_ext[AW-1:0]] <= point_x;
			mem_y[idx_ext[AW-1:0]] <= point_y;
		end
		rdx_q <= mem_x[addr_q];
		rdy_q <= mem_y[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_range_q  <= LINE_RANGE_RST;
			point_count_q <= POINT_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LINE_RANGE:  line_range_q  <= cfg_data;
				CFG_POINT_COUNT: point_count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dmode_q   <= DM_X;
			held_x_q  <= '0;
			held_y_q  <= '0;
			out_valid <= 1'b0;
			have_q    <= 1'b0;
			hit_q     <= 1'b0;
			pv_q      <= 1'b0;
			dcnt_q    <= '0;
			scnt_q    <= '0;
			nxt_q     <= '0;
			n_q       <= '0;
			addr_q    <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_DONE) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && req_type == REQ_QUERY) begin
						rx_q   <= robot_x;
						ry_q   <= robot_y;
						n_q    <= n_new;
						have_q <= 1'b0;
						hit_q  <= 1'b0;
						dist_q <= '0;
						addr_q <= '0;
						nxt_q  <= CW'(1);
						if (n_new < CW'(2)) begin
							pv_q    <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							pv_q    <= 1'b1;
							state_q <= ST_WA;
						end
					end
				end
				ST_WA: state_q <= ST_GA;
				ST_GA: begin
					ax_q    <= rdx_q;
					ay_q    <= rdy_q;
					addr_q  <= nxt_q[AW-1:0];
					state_q <= ST_WB;
				end
				ST_WB: state_q <= ST_GB;
				ST_GB: begin
					bx_q    <= rdx_q;
					by_q    <= rdy_q;
					state_q <= ST_DEN0;
				end
				ST_DEN0: begin acc_q <= prod_ext; state_q <= ST_DEN1; end
				ST_DEN1: begin den_q <= acc_sum[33:0]; state_q <= ST_NUM0; end
				ST_NUM0: begin acc_q <= prod_ext; state_q <= ST_NUM1; end
				ST_NUM1: begin
					num_q <= acc_sum[34:0];
					if (den_q == '0) begin
						// both ends equal: the waypoint itself
						cx_q    <= ax_q;
						cy_q    <= ay_q;
						state_q <= ST_SQ0;
					end else begin
						state_q <= ST_PX0;
					end
				end
				ST_PX0: begin acc_q <= {prod_ext[36:0], 17'd0}; state_q <= ST_PX1; end
				ST_PX1: begin
					acc_q   <= acc_sum;
					dmode_q <= DM_X;
					state_q <= ST_DSET;
				end
				ST_PY0: begin acc_q <= {prod_ext[36:0], 17'd0}; state_q <= ST_PY1; end
				ST_PY1: begin
					acc_q   <= acc_sum;
					dmode_q <= DM_Y;
					state_q <= ST_DSET;
				end
				ST_DSET: begin
					neg_q   <= (dmode_q != DM_W) && acc_q[53];
					dwork_q <= dv_work;
					dsh_q   <= dv_sh0;
					dcnt_q  <= '0;
					if (dv_sat) begin
						// quotient beyond any box: the clamp decides
						dq_q    <= '1;
						state_q <= ST_DFIN;
					end else begin
						dq_q    <= '0;
						state_q <= ST_DSTEP;
					end
				end
				ST_DSTEP: begin
					if (dv_ge) dwork_q <= dv_diff;
					dq_q   <= {dq_q[DIV_QB-2:0], dv_ge};
					dsh_q  <= dsh_q >> 1;
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'(DIV_QB - 1)) state_q <= ST_DFIN;
				end
				ST_DFIN: begin
					case (dmode_q)
						DM_X: begin cx_q <= cres; state_q <= ST_PY0; end
						DM_Y: begin cy_q <= cres; state_q <= ST_SQ0; end
						DM_W: begin wn_q <= dq_q[16:0]; state_q <= ST_BLX0; end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_SQ0: begin acc_q <= prod_ext; state_q <= ST_SQ1; end
				ST_SQ1: begin
					if (take_best) begin
						// ties go to the later segment
						have_q  <= 1'b1;
						best_q  <= sq_new;
						bestx_q <= cx_q;
						besty_q <= cy_q;
						endx_q  <= bx_q;
						endy_q  <= by_q;
					end
					if (nxt_inc < {1'b0, n_q}) begin
						ax_q    <= bx_q;
						ay_q    <= by_q;
						nxt_q   <= nxt_inc[CW-1:0];
						addr_q  <= nxt_inc[AW-1:0];
						state_q <= ST_WB;
					end else begin
						state_q <= ST_SQI;
					end
				end
				ST_SQI: begin
					sv_q    <= best_q;
					sr_q    <= '0;
					sb_q    <= 34'h1_0000_0000;
					scnt_q  <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_ge) begin
						sv_q <= sv_q - sq_t[33:0];
						sr_q <= (sr_q >> 1) + {1'b0, sb_q};
					end else begin
						sr_q <= sr_q >> 1;
					end
					sb_q   <= sb_q >> 2;
					scnt_q <= scnt_q + 5'd1;
					if (scnt_q == 5'(SQRT_STEPS - 1)) state_q <= ST_RNG;
				end
				ST_RNG: begin
					dist_q <= sr_q[16:0];
					if (best_q <= {2'b0, prod[31:0]}) begin
						hit_q <= 1'b1;
						if (line_range_q != '0) begin
							dmode_q <= DM_W;
							state_q <= ST_DSET;
						end else begin
							wn_q    <= '0;
							state_q <= ST_BLX0;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_BLX0: begin acc_q <= prod_ext; state_q <= ST_BLX1; end
				ST_BLX1: begin held_x_q <= blend_s[31:16]; state_q <= ST_BLY0; end
				ST_BLY0: begin acc_q <= prod_ext; state_q <= ST_BLY1; end
				ST_BLY1: begin held_y_q <= blend_s[31:16]; state_q <= ST_DONE; end
				ST_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid        <= 1'b1;
						motion_x         <= held_x_q;
						motion_y         <= held_y_q;
						nearest_distance <= dist_q;
						in_range         <= hit_q;
						path_valid       <= pv_q;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_short_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (path_valid || !in_range))
		else $error("in_range set on a short path");

	a_short_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && req_type == REQ_QUERY && n_new < CW'(2))
		|=> state_q == ST_DONE)
		else $error("short path query did not finish at once");

	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && in_range) |-> ({1'b0, line_range_q} >= nearest_distance))
		else $error("in range with distance above line_range");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSTEP) |-> (dcnt_q < 5'(DIV_QB)))
		else $error("divider ran past its quotient width");

endmodule
